// ===== src/two_input_sqrt_crossfader_assert.svh =====
// ---------------------------------------------------------------------------
// Crossfader assertion macros
// Shorthand for the concurrent checks placed at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef TWO_INPUT_SQRT_CROSSFADER_ASSERT_SVH
`define TWO_INPUT_SQRT_CROSSFADER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TISC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crossfader check failed");

// The consequent must hold in the cycle after the antecedent.
`define TISC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crossfader check failed");

`endif

// ===== src/tisc_pkg.sv =====
// ---------------------------------------------------------------------------
// Crossfader package
// Fixed constants, item codes, state and status types of the crossfader.
// ---------------------------------------------------------------------------
package tisc_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  // The quotient count/length is formed with 32 fraction bits, so its
  // square root carries 16 fraction bits (the Q1.16 gain).
  localparam int QUOT_BITS = 32;
  localparam int ROOT_BITS = QUOT_BITS / 2;
  localparam int GAIN_BITS = ROOT_BITS + 1;
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << ROOT_BITS;

  // Sequencer of the serial engine: division steps, interleaved root and
  // multiply steps, the last multiply step lands in the cycle after the last
  // root step.
  localparam int STEP_LAST  = QUOT_BITS + 1;
  localparam int STEP_W     = $clog2(STEP_LAST + 1);
  localparam int SQRT_FIRST = 2;
  localparam int MUL_FIRST  = 3;

  // Fade length after reset, clipped when the counter is narrower.
  localparam int DEFAULT_FADE      = 2205;
  localparam int DEFAULT_FADE_BITS = 12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } tisc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } tisc_eng_stat_t;

endpackage

// ===== src/tisc_if.sv =====
// ---------------------------------------------------------------------------
// Crossfader channels
// Valid/ready channels for input items and for mixed result items.
// ---------------------------------------------------------------------------
interface tisc_in_if #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 20
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample_a;
  logic signed [SAMPLE_BITS-1:0] sample_b;
  logic [COUNT_BITS-1:0]         fade_len;

  modport source (output valid, kind, sample_a, sample_b, fade_len, input ready);
  modport sink   (input valid, kind, sample_a, sample_b, fade_len, output ready);
endinterface

interface tisc_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mixed_sample;
  logic [16:0]                   gain;
  logic                          fading;

  modport source (output valid, mixed_sample, gain, fading, input ready);
  modport sink   (input valid, mixed_sample, gain, fading, output ready);
endinterface

// ===== src/two_input_sqrt_crossfader.sv =====
// ---------------------------------------------------------------------------
// Two-input square-root crossfader
// A switch item flips which input is the new one, loads the fade length in
// samples (zero is taken as one) and restarts the fade; it has no result.
// A sample item carries one sample of each input and yields one result: the
// mixed sample, the Q1.16 gain on the new input (65536 is unity) and a flag
// that is high inside the fade. The fade gain sqrt(count/length) comes from
// a serial divider feeding a digit-serial square root, whose digits feed an
// MSB-first shift-add multiplier.
// A switch item is applied when it is accepted. A sample item outside a fade
// goes to the output register from the hold state; inside a fade it first runs
// the engine for 34 steps (32 division steps, then the last root and multiply
// steps), then the sequencer sees the engine finish and loads the output.
// One item is worked on at a time; the next is taken the cycle after the
// result is loaded.
// Reset clears the fade, selects the first input and sets the fade length to
// 2205 samples. When the receiver stalls, the result waits in the output
// register; one more item is accepted and computed, and its result waits
// internally, with the input stalled, until the output register frees up.
// ---------------------------------------------------------------------------
`include "two_input_sqrt_crossfader_assert.svh"

module two_input_sqrt_crossfader import tisc_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tisc_in_if.sink   in_i,
  tisc_out_if.source out_o
);

  // The reset length, clipped to the largest count when the counter is too
  // narrow to hold it.
  localparam logic [COUNT_BITS-1:0] FadeDefault =
    (COUNT_BITS >= DEFAULT_FADE_BITS) ? COUNT_BITS'(DEFAULT_FADE) : '1;

  tisc_state_e state_q, state_d;

  // Fade state.
  logic                  new_is_second_q;
  logic                  fade_active_q;
  logic [COUNT_BITS-1:0] fade_count_q;
  logic [COUNT_BITS-1:0] fade_length_q;

  // Operands of the item in flight.
  logic signed [SAMPLE_BITS-1:0] nw_q, od_q;
  logic                          fading_q;

  // Output register.
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic [GAIN_BITS-1:0]          out_gain_q;
  logic                          out_fading_q;

  logic signed [SAMPLE_BITS-1:0] nw, od;
  logic signed [SAMPLE_BITS:0]   diff;
  logic                          fade_now;
  logic                          in_ready, in_acc, out_free, out_load, eng_start;
  logic signed [SAMPLE_BITS-1:0] mix;

  tisc_eng_stat_t                       eng_stat;
  logic [ROOT_BITS-1:0]                 eng_root;
  logic signed [SAMPLE_BITS+ROOT_BITS:0] eng_prod;

  // Route the two inputs into new and old roles.
  always_comb begin
    nw       = new_is_second_q ? in_i.sample_b : in_i.sample_a;
    od       = new_is_second_q ? in_i.sample_a : in_i.sample_b;
    diff     = {nw[SAMPLE_BITS-1], nw} - {od[SAMPLE_BITS-1], od};
    fade_now = fade_active_q && (fade_count_q < fade_length_q);
  end

  // Output of the mix: old*65536 + diff*g, floored by 65536, is the old
  // sample plus the arithmetic shift of the product.
  assign mix = od_q + eng_prod[SAMPLE_BITS+ROOT_BITS-1:ROOT_BITS];

  assign out_free = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.kind == KIND_SAMPLE)) begin
          state_d = fade_now ? ST_RUN : ST_HOLD;
        end
      end
      ST_RUN: begin
        if (eng_stat.done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  in_ready = 1'b0;
      ST_HOLD: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
    eng_start = in_acc && (in_i.kind == KIND_SAMPLE) && fade_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      new_is_second_q <= 1'b0;
      fade_active_q   <= 1'b0;
      fade_count_q    <= '0;
      fade_length_q   <= FadeDefault;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (in_i.kind == KIND_SWITCH) begin
          // A switch during a fade flips the roles at once and starts over.
          new_is_second_q <= !new_is_second_q;
          fade_count_q    <= '0;
          fade_length_q   <= (in_i.fade_len == '0) ? COUNT_BITS'(1) : in_i.fade_len;
          fade_active_q   <= 1'b1;
        end else if (fade_now) begin
          fade_count_q <= fade_count_q + COUNT_BITS'(1);
        end else begin
          fade_active_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.kind == KIND_SAMPLE)) begin
      nw_q     <= nw;
      od_q     <= od;
      fading_q <= fade_now;
    end
    if (out_load) begin
      out_sample_q <= fading_q ? mix : nw_q;
      out_gain_q   <= fading_q ? {1'b0, eng_root} : GAIN_ONE;
      out_fading_q <= fading_q;
    end
  end

  tisc_engine #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eng_start),
    .count_i  (fade_count_q),
    .length_i (fade_length_q),
    .diff_i   (diff),
    .stat_o   (eng_stat),
    .root_o   (eng_root),
    .prod_o   (eng_prod)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.mixed_sample = out_sample_q;
  assign out_o.gain         = out_gain_q;
  assign out_o.fading       = out_fading_q;

  // A new item is only taken while the serial engine is free.
  `TISC_ASSERT_SAME(a_ready_engine_free, clk_i, rst_ni, in_ready, !eng_stat.busy)
  // The engine only finishes while the sequencer waits for it.
  `TISC_ASSERT_SAME(a_done_in_run, clk_i, rst_ni, eng_stat.done, state_q == ST_RUN)
  // The fade counter never runs past the fade length.
  `TISC_ASSERT_SAME(a_count_bound, clk_i, rst_ni, fade_active_q,
                    fade_count_q <= fade_length_q)
  // A result taken inside a fade carries a gain below unity.
  `TISC_ASSERT_NEXT(a_fade_gain, clk_i, rst_ni, out_load && fading_q,
                    out_gain_q < GAIN_ONE)

endmodule

// ===== src/tisc_engine.sv =====
// ---------------------------------------------------------------------------
// Crossfader serial gain engine
// Bit-serial division, digit-serial square root and MSB-first multiply,
// chained so each stage consumes the previous stage's digits as they appear.
// ---------------------------------------------------------------------------
module tisc_engine import tisc_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 20
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [COUNT_BITS-1:0]                  count_i,
  input  logic [COUNT_BITS-1:0]                  length_i,
  input  logic signed [SAMPLE_BITS:0]            diff_i,
  output tisc_eng_stat_t                         stat_o,
  output logic [ROOT_BITS-1:0]                   root_o,
  output logic signed [SAMPLE_BITS+ROOT_BITS:0]  prod_o
);

  localparam int AccW = SAMPLE_BITS + ROOT_BITS + 1;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      step_q, step_d;

  logic [COUNT_BITS-1:0]  rem_q, rem_d;
  logic [COUNT_BITS-1:0]  len_q;
  logic [1:0]             qpair_q, qpair_d;
  logic [ROOT_BITS+1:0]   srem_q, srem_d;
  logic [ROOT_BITS-1:0]   root_q, root_d;
  logic signed [SAMPLE_BITS:0] diff_q;
  logic signed [AccW-1:0] acc_q, acc_d;

  logic                   div_en, sqrt_en, mul_en;
  logic [COUNT_BITS:0]    rem_sh, len_ext, rem_sub;
  logic                   qbit;
  logic [ROOT_BITS+3:0]   srad, strial, sdiff;
  logic                   sbit;
  logic signed [AccW-1:0] addend;

  // Step plan: division at steps 0..31, a root digit at each even step from
  // step 2 on, a multiply step the cycle after each root digit.
  always_comb begin
    div_en  = busy_q && (step_q < STEP_W'(QUOT_BITS));
    sqrt_en = busy_q && (step_q >= STEP_W'(SQRT_FIRST)) && !step_q[0];
    mul_en  = busy_q && (step_q >= STEP_W'(MUL_FIRST)) && step_q[0];
  end

  // Restoring division of count * 2^32 by length; the remainder stays
  // below the length, so one quotient bit appears per step.
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    len_ext = {1'b0, len_q};
    rem_sub = rem_sh - len_ext;
    qbit    = (rem_sh >= len_ext);
    rem_d   = qbit ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
    qpair_d = {qpair_q[0], qbit};
  end

  // Digit-by-digit square root on the quotient bit pairs.
  always_comb begin
    srad   = {srem_q, qpair_q};
    strial = {2'b00, root_q, 2'b01};
    sdiff  = srad - strial;
    sbit   = (srad >= strial);
    srem_d = sbit ? sdiff[ROOT_BITS+1:0] : srad[ROOT_BITS+1:0];
    root_d = {root_q[ROOT_BITS-2:0], sbit};
  end

  // Horner multiply of the sample difference by the root, MSB first.
  always_comb begin
    addend = root_q[0] ? {{(AccW-SAMPLE_BITS-1){diff_q[SAMPLE_BITS]}}, diff_q}
                       : AccW'(0);
    acc_d  = {acc_q[AccW-2:0], 1'b0} + addend;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(STEP_LAST)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= count_i;
      len_q   <= length_i;
      qpair_q <= '0;
      srem_q  <= '0;
      root_q  <= '0;
      diff_q  <= diff_i;
      acc_q   <= '0;
    end else begin
      if (div_en) begin
        rem_q   <= rem_d;
        qpair_q <= qpair_d;
      end
      if (sqrt_en) begin
        srem_q <= srem_d;
        root_q <= root_d;
      end
      if (mul_en) begin
        acc_q <= acc_d;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;
  assign prod_o      = acc_q;

endmodule
